// ----- src/fps_pkg.sv -----
// ---------------------------------------------------------------------------
// fps_pkg
// Shared sizes, codes and types for the Fenwick prefix-sum tree.
// ---------------------------------------------------------------------------
package fps_pkg;

    // Number of counters held by the tree
    localparam int SIZE   = 8192;
    // Address of one tree node in the store (node k lives at k-1)
    localparam int ADDR_W = (SIZE > 1) ? $clog2(SIZE) : 1;
    // Node index; wide enough for SIZE and for one step past it
    localparam int NODE_W = $clog2(SIZE) + 2;
    // Fixed field widths
    localparam int POS_W  = 14;
    localparam int DATA_W = 32;

    // Item kind codes
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } fps_state_t;

    // Request from the sequencer to the node store
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } fps_ram_req_t;

endpackage

// ----- src/fenwick_prefix_sum_tree.sv -----
// ---------------------------------------------------------------------------
// fenwick_prefix_sum_tree
// Binary indexed tree over SIZE signed 32-bit counters with add and
// prefix-sum query items.
// ---------------------------------------------------------------------------
// After reset the block clears its node store, one entry per cycle, over all
// SIZE entries (8192 at the default size); s_ready stays low until that pass
// ends. Items are then handled one at a time. An add at position p walks the
// nodes p+1, p+1+lowbit, ... up to SIZE, at most log2(SIZE)+1 nodes (14 at the
// default size); a query of length n walks popcount(n) nodes. The node store
// is a single RAM with one read port, one write port and registered read
// data: one node read is issued per cycle while the previous node is written
// back or accumulated, so an item passes through accept, the node reads, the
// last write-back and a drain step, in which a query result waits for a free
// output register. An add at a position of SIZE or above changes nothing and
// gives no result; a query length above SIZE sums all elements. Query results
// sit in an output register, so the next item is taken while a result waits for m_ready.
// ---------------------------------------------------------------------------
module fenwick_prefix_sum_tree
    import fps_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // item channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_delta,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_prefix_sum
);

    fps_ram_req_t        ram_req;
    logic [DATA_W-1:0]   ram_rd_data;
    logic                res_valid;
    logic                res_ready;
    logic [DATA_W-1:0]   res_sum;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_sum_reg, m_sum_next;

    // Walk sequencer
    fps_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_position  (s_position),
        .s_delta     (s_delta),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_sum     (res_sum),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

    // Node store
    fps_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register: free when empty or being taken this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_sum_next   = m_sum_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_sum_next   = res_sum;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_sum_reg <= m_sum_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_prefix_sum = m_sum_reg;

endmodule

// ----- src/fps_ram.sv -----
// ---------------------------------------------------------------------------
// fps_ram
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered.
// ---------------------------------------------------------------------------
module fps_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/fps_engine.sv -----
// ---------------------------------------------------------------------------
// fps_engine
// Tree walk sequencer: clears the node store after reset, then walks the
// nodes of each item, one read issued per cycle, with the write-back or
// accumulation of the previous node in the same cycle.
// ---------------------------------------------------------------------------
module fps_engine
    import fps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // item input
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [POS_W-1:0]    s_position,
    input  logic [DATA_W-1:0]   s_delta,
    // query result towards the output stage
    output logic                res_valid,
    input  logic                res_ready,
    output logic [DATA_W-1:0]   res_sum,
    // node store
    output fps_ram_req_t        ram_req,
    input  logic [DATA_W-1:0]   ram_rd_data
);

    fps_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                kind_reg, kind_next;
    logic [DATA_W-1:0]   delta_reg, delta_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [ADDR_W-1:0]   rd_addr_reg, rd_addr_next;

    logic                issue;
    logic                walk_empty;
    logic                walk_done;
    logic [NODE_W-1:0]   low_bit;
    logic [NODE_W-1:0]   node_step;
    logic [NODE_W-1:0]   start_node;
    logic [31:0]         pos_ext;

    // Walk bookkeeping
    assign issue      = (node_reg != '0) && ({{(32-NODE_W){1'b0}}, node_reg} <= 32'(SIZE));
    assign walk_empty = !issue && !rd_pend_reg;
    assign walk_done  = walk_empty && ((kind_reg == KIND_ADD) || res_ready);
    assign low_bit    = node_reg & (~node_reg + 1'b1);
    assign node_step  = (kind_reg == KIND_ADD) ? (node_reg + low_bit)
                                               : (node_reg & (node_reg - 1'b1));

    // First node of a new item; an add out of range walks nothing
    assign pos_ext = {{(32-POS_W){1'b0}}, s_position};
    always_comb begin
        if (s_kind == KIND_ADD) begin
            start_node = (pos_ext < 32'(SIZE)) ? NODE_W'(pos_ext + 32'd1) : '0;
        end else begin
            start_node = (pos_ext > 32'(SIZE)) ? NODE_W'(SIZE) : NODE_W'(pos_ext);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == ADDR_W'(SIZE - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready         = 1'b0;
        res_valid       = 1'b0;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = rd_addr_reg;
        ram_req.wr_data = ram_rd_data + delta_reg;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = ADDR_W'(node_reg - 1'b1);
        case (state_reg)
            ST_CLEAR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = clr_cnt_reg;
                ram_req.wr_data = '0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_WALK: begin
                ram_req.rd_en = issue;
                ram_req.wr_en = rd_pend_reg && (kind_reg == KIND_ADD);
                res_valid     = walk_empty && (kind_reg == KIND_QUERY);
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign res_sum = acc_reg;

    // Datapath next values
    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        kind_next    = kind_reg;
        delta_next   = delta_reg;
        node_next    = node_reg;
        acc_next     = acc_reg;
        rd_pend_next = 1'b0;
        rd_addr_next = rd_addr_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_kind;
                    delta_next = s_delta;
                    node_next  = start_node;
                    acc_next   = '0;
                end
            end
            ST_WALK: begin
                rd_pend_next = issue;
                if (issue) begin
                    node_next    = node_step;
                    rd_addr_next = ram_req.rd_addr;
                end
                if (rd_pend_reg && (kind_reg == KIND_QUERY)) begin
                    acc_next = acc_reg + ram_rd_data;
                end
            end
            default: begin
                clr_cnt_next = '0;
            end
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        delta_reg   <= delta_next;
        node_reg    <= node_next;
        acc_reg     <= acc_next;
        rd_addr_reg <= rd_addr_next;
    end

    // A write-back never lands on the entry being read in the same cycle
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.wr_addr != ram_req.rd_addr))
        else $error("fps_engine: write and read hit the same node");

    // Read data is consumed only in the cycle after a read was issued
    a_pend_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> $past(ram_req.rd_en))
        else $error("fps_engine: pending read without a read issued");

    // A new item may enter only once the previous walk has fully drained
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!rd_pend_reg && !ram_req.wr_en))
        else $error("fps_engine: item accepted with node traffic in flight");

    // Every returned read of an add is written back
    a_add_writeback: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_pend_reg && (kind_reg == KIND_ADD)) |-> ram_req.wr_en)
        else $error("fps_engine: add read without write-back");

endmodule
